[hw/rtl/bdq_pkg.sv]
// Package for the bounded deque: sizes, codes, payload and command types, ring helpers.
`default_nettype none
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = AW + 1;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] MODE_INS_REAR  = 3'd0;
  localparam logic [2:0] MODE_INS_FRONT = 3'd1;
  localparam logic [2:0] MODE_REM_FRONT = 3'd2;
  localparam logic [2:0] MODE_REM_REAR  = 3'd3;
  localparam logic [2:0] MODE_LIST      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [AW-1:0]      addr;
    logic [CW-1:0]      cnt;
    logic signed [31:0] value;
    logic [1:0]         status;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  // base + off wrapped into the ring; off never exceeds DEPTH
  function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bdq_front.sv]
// Front end: accepts requests, tracks front pointer and count, issues commands.
`default_nettype none
module bdq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire bdq_pkg::req_t req,
  input  wire logic          q_full,
  output logic               push,
  output bdq_pkg::cmd_t      push_cmd
);

  logic [bdq_pkg::AW-1:0] fp, fp_next;
  logic [bdq_pkg::CW-1:0] count, count_next;
  logic                   accept;
  logic                   is_full;
  logic                   is_empty;

  assign accept   = req_valid && !q_full;
  assign is_full  = (count == bdq_pkg::CW'(bdq_pkg::DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    fp_next         = fp;
    count_next      = count;
    push            = 1'b0;
    push_cmd.kind   = bdq_pkg::CMD_STATUS;
    push_cmd.addr   = fp;
    push_cmd.cnt    = bdq_pkg::CW'(1);
    push_cmd.value  = req.value;
    push_cmd.status = bdq_pkg::ST_OK;
    if (accept) begin
      case (req.mode) inside
        bdq_pkg::MODE_INS_REAR, bdq_pkg::MODE_INS_FRONT: begin
          push = 1'b1;
          if (is_full) begin
            push_cmd.status = bdq_pkg::ST_FULL;
          end else begin
            push_cmd.kind = bdq_pkg::CMD_WRITE;
            count_next    = count + bdq_pkg::CW'(1);
            if (req.mode == bdq_pkg::MODE_INS_REAR) begin
              push_cmd.addr = bdq_pkg::ring_at(fp, count);
            end else begin
              fp_next       = bdq_pkg::slot_dec(fp);
              push_cmd.addr = bdq_pkg::slot_dec(fp);
            end
          end
        end
        bdq_pkg::MODE_REM_FRONT, bdq_pkg::MODE_REM_REAR: begin
          push = 1'b1;
          if (is_empty) begin
            push_cmd.status = bdq_pkg::ST_EMPTY;
          end else begin
            push_cmd.kind = bdq_pkg::CMD_READ;
            count_next    = count - bdq_pkg::CW'(1);
            if (req.mode == bdq_pkg::MODE_REM_FRONT) begin
              push_cmd.addr = fp;
              fp_next       = bdq_pkg::slot_inc(fp);
            end else begin
              push_cmd.addr = bdq_pkg::ring_at(fp, count - bdq_pkg::CW'(1));
            end
          end
        end
        bdq_pkg::MODE_LIST: begin
          push = 1'b1;
          if (is_empty) begin
            push_cmd.status = bdq_pkg::ST_EMPTY;
          end else begin
            push_cmd.kind = bdq_pkg::CMD_READ;
            push_cmd.addr = fp;
            push_cmd.cnt  = count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp    <= '0;
      count <= '0;
    end else begin
      fp    <= fp_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bdq_cmd_fifo.sv]
// Short command queue between front end and back end.
`default_nettype none
module bdq_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bdq_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output bdq_pkg::cmd_t      head
);

  bdq_pkg::cmd_t           slots [bdq_pkg::QDEPTH];
  logic [bdq_pkg::QAW-1:0] wr_ptr;
  logic [bdq_pkg::QAW-1:0] rd_ptr;
  logic [bdq_pkg::QCW-1:0] fill;
  logic                    do_push;
  logic                    do_pop;

  assign full       = (fill == bdq_pkg::QCW'(bdq_pkg::QDEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + bdq_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + bdq_pkg::QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + bdq_pkg::QCW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - bdq_pkg::QCW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bdq_back.sv]
// Back end: executes commands against the entry RAM and drives the result register.
`default_nettype none
module bdq_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire bdq_pkg::cmd_t head,
  output logic               pop,
  output logic               res_valid,
  input  wire logic          res_stall,
  output bdq_pkg::res_t      res
);

  bdq_pkg::back_state_t   state, state_next;
  logic [bdq_pkg::AW-1:0] cur_addr;
  logic [bdq_pkg::CW-1:0] remain;
  logic                   out_free;
  logic                   load;
  bdq_pkg::res_t          res_next;
  logic                   ram_we;
  logic                   ram_re;
  logic [bdq_pkg::AW-1:0] ram_raddr;
  logic [31:0]            ram_rdata;
  logic                   at_end;

  assign out_free = !res_valid || !res_stall;
  assign at_end   = (remain == bdq_pkg::CW'(1));

  bdq_ram #(
    .WIDTH(32),
    .DEPTH(bdq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head.addr),
    .wdata(head.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      bdq_pkg::B_IDLE: begin
        if (head_valid && out_free && head.kind == bdq_pkg::CMD_READ) begin
          state_next = bdq_pkg::B_READ;
        end
      end
      bdq_pkg::B_READ: begin
        if (out_free && at_end) begin
          state_next = bdq_pkg::B_IDLE;
        end
      end
      default: state_next = bdq_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head.addr;
    res_next  = '{value_res: '0, status: bdq_pkg::ST_OK, last: 1'b1};
    case (state)
      bdq_pkg::B_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          case (head.kind)
            bdq_pkg::CMD_WRITE: begin
              ram_we             = 1'b1;
              load               = 1'b1;
              res_next.value_res = head.value;
            end
            bdq_pkg::CMD_READ: begin
              ram_re = 1'b1;
            end
            default: begin
              load            = 1'b1;
              res_next.status = head.status;
            end
          endcase
        end
      end
      bdq_pkg::B_READ: begin
        if (out_free) begin
          load               = 1'b1;
          res_next.value_res = ram_rdata;
          res_next.last      = at_end;
          if (!at_end) begin
            ram_re    = 1'b1;
            ram_raddr = bdq_pkg::slot_inc(cur_addr);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == bdq_pkg::B_IDLE && ram_re) begin
      cur_addr <= head.addr;
      remain   <= head.cnt;
    end else if (ram_re) begin
      cur_addr <= ram_raddr;
      remain   <= remain - bdq_pkg::CW'(1);
    end
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bounded_deque.sv]
// Bounded deque top level: front end, command queue and back end.
// Insert or status result: passes the command queue and the result register.
// Removal: queue, RAM read and result registers. A listing of N entries gives one
// entry per cycle, one insert per cycle, unless stalled; no new command in B_READ.
// Reset (synchronous): empties the deque, queue and result register; RAM not cleared.
`default_nettype none
module bounded_deque (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire bdq_pkg::req_t cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output bdq_pkg::res_t      res
);

  logic          q_full;
  logic          push;
  bdq_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  bdq_pkg::cmd_t head;

  assign cmd_stall = q_full;

  bdq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(cmd_valid),
    .req      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bdq_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  bdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

[tb/sv/bounded_deque_tb.sv]
// Self-checking testbench for bounded_deque: directed table and random requests.
`timescale 1ns / 100ps

module bounded_deque_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RAND_ITEMS   = 100;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [2:0] INS_REAR  = bdq_pkg::MODE_INS_REAR;
  localparam logic [2:0] INS_FRONT = bdq_pkg::MODE_INS_FRONT;
  localparam logic [2:0] REM_FRONT = bdq_pkg::MODE_REM_FRONT;
  localparam logic [2:0] REM_REAR  = bdq_pkg::MODE_REM_REAR;
  localparam logic [2:0] LIST_ALL  = bdq_pkg::MODE_LIST;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [4:0]         reps;
    logic               rnd;
    logic               typed;
    logic signed [31:0] want_value;
    logic [1:0]         want_status;
  } plan_row_t;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_stall;
  bdq_pkg::req_t cmd;
  logic          res_valid;
  logic          res_stall;
  bdq_pkg::res_t res;

  bdq_pkg::res_t      owed[$];
  bdq_pkg::res_t      fresh[$];
  plan_row_t          plan[$];
  logic signed [31:0] ring_q[bdq_pkg::DEPTH];
  int                 head;
  int                 fill;
  int                 errors;
  int                 cycle_count = 0;
  bit                 burst;
  bit                 hold_req;

  bounded_deque i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("bounded_deque_tb: FAIL");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic bdq_pkg::res_t make_res(input logic signed [31:0] v,
                                             input logic [1:0] s, input logic l);
    bdq_pkg::res_t r;
    r.value_res = v;
    r.status    = s;
    r.last      = l;
    return r;
  endfunction

  function automatic plan_row_t row(input logic [2:0] m, input logic signed [31:0] v,
                                    input int reps, input bit rnd, input bit typed,
                                    input logic signed [31:0] wv, input logic [1:0] ws);
    plan_row_t p;
    p.mode        = m;
    p.value       = v;
    p.reps        = reps[4:0];
    p.rnd         = rnd;
    p.typed       = typed;
    p.want_value  = wv;
    p.want_status = ws;
    return p;
  endfunction

  // deque predictor: updates the ring and fills 'fresh' with the results of one request
  function automatic void deque_apply(input bdq_pkg::req_t r);
    int slot;
    int k;
    fresh.delete();
    case (r.mode)
      INS_REAR, INS_FRONT: begin
        if (fill >= bdq_pkg::DEPTH) begin
          fresh.push_back(make_res(0, bdq_pkg::ST_FULL, 1'b1));
        end else begin
          if (r.mode == INS_REAR) begin
            slot = (head + fill) % bdq_pkg::DEPTH;
          end else begin
            head = (head + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
            slot = head;
          end
          ring_q[bdq_pkg::AW'(slot)] = r.value;
          fill++;
          fresh.push_back(make_res(r.value, bdq_pkg::ST_OK, 1'b1));
        end
      end
      REM_FRONT, REM_REAR: begin
        if (fill == 0) begin
          fresh.push_back(make_res(0, bdq_pkg::ST_EMPTY, 1'b1));
        end else begin
          if (r.mode == REM_FRONT) begin
            slot = head;
            head = (head + 1) % bdq_pkg::DEPTH;
          end else begin
            slot = (head + fill - 1) % bdq_pkg::DEPTH;
          end
          fill--;
          fresh.push_back(make_res(ring_q[bdq_pkg::AW'(slot)], bdq_pkg::ST_OK, 1'b1));
        end
      end
      LIST_ALL: begin
        if (fill == 0) begin
          fresh.push_back(make_res(0, bdq_pkg::ST_EMPTY, 1'b1));
        end else begin
          for (k = 0; k < fill; k++) begin
            slot = (head + k) % bdq_pkg::DEPTH;
            fresh.push_back(make_res(ring_q[bdq_pkg::AW'(slot)], bdq_pkg::ST_OK,
                                     k == fill - 1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input bdq_pkg::req_t r, input bit typed,
                          input logic signed [31:0] wv, input logic [1:0] ws);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= r;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    deque_apply(r);
    if (typed) begin
      owed.push_back(make_res(wv, ws, 1'b1));
    end else begin
      foreach (fresh[i]) owed.push_back(fresh[i]);
    end
  endtask

  // result side
  initial begin
    int            n;
    bdq_pkg::res_t want;
    res_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      n = draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (res_valid !== 1'b1);
      if (owed.size() == 0) begin
        note_error($sformatf("unexpected result value %0d status %0d last %0d",
                             res.value_res, res.status, res.last));
      end else begin
        want = owed.pop_front();
        if (res.value_res !== want.value_res)
          note_error($sformatf("value_res %0d, want %0d", res.value_res, want.value_res));
        if (res.status !== want.status)
          note_error($sformatf("status %0d, want %0d", res.status, want.status));
        if (res.last !== want.last)
          note_error($sformatf("last %0b, want %0b", res.last, want.last));
      end
    end
  end

  // request side
  initial begin
    bdq_pkg::req_t r;
    int            counted;
    int            pick;
    bit            lean;
    errors    = 0;
    head      = 0;
    fill      = 0;
    burst     = 1'b0;
    hold_req  = 1'b0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    //                 mode       value         reps rnd   typed want_value    want_status
    plan.push_back(row(LIST_ALL,  0,            1,   1'b0, 1'b1, 0,            bdq_pkg::ST_EMPTY));
    plan.push_back(row(REM_FRONT, 0,            1,   1'b0, 1'b1, 0,            bdq_pkg::ST_EMPTY));
    plan.push_back(row(REM_REAR,  0,            1,   1'b0, 1'b1, 0,            bdq_pkg::ST_EMPTY));
    plan.push_back(row(INS_REAR,  32'h7fffffff, 1,   1'b0, 1'b1, 32'h7fffffff, bdq_pkg::ST_OK));
    plan.push_back(row(REM_REAR,  0,            1,   1'b0, 1'b1, 32'h7fffffff, bdq_pkg::ST_OK));
    plan.push_back(row(LIST_ALL,  0,            1,   1'b0, 1'b1, 0,            bdq_pkg::ST_EMPTY));
    plan.push_back(row(INS_FRONT, 32'h80000000, 1,   1'b0, 1'b1, 32'h80000000, bdq_pkg::ST_OK));
    plan.push_back(row(INS_REAR,  -1,           1,   1'b0, 1'b1, -1,           bdq_pkg::ST_OK));
    plan.push_back(row(INS_FRONT, 0,            1,   1'b0, 1'b1, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(LIST_ALL,  0,            1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(3'd5,      32'h12345678, 1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(3'd7,      -1,           1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(INS_FRONT, 0,            13,  1'b1, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(INS_REAR,  32'h55aa55aa, 1,   1'b0, 1'b1, 0,            bdq_pkg::ST_FULL));
    plan.push_back(row(INS_FRONT, -1,           1,   1'b0, 1'b1, 0,            bdq_pkg::ST_FULL));
    plan.push_back(row(LIST_ALL,  0,            1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(REM_FRONT, 0,            1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));
    plan.push_back(row(REM_REAR,  0,            1,   1'b0, 1'b0, 0,            bdq_pkg::ST_OK));

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        r.mode  = plan[i].mode;
        r.value = plan[i].rnd ? $urandom : plan[i].value;
        send_req(r, plan[i].typed, plan[i].want_value, plan[i].want_status);
      end
    end

    // long result hold-off at the start of the random part fills the block up
    hold_req = 1'b1;
    counted  = 0;
    lean     = 1'b1;
    while (counted < RAND_ITEMS) begin
      if (counted % 16 == 0) lean = 1'($urandom_range(0, 1));
      if (counted % 20 == 0) burst = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5)
        r.mode = 3'($urandom_range(5, 7));
      else if (pick < 13)
        r.mode = LIST_ALL;
      else if (pick < (lean ? 73 : 40))
        r.mode = $urandom_range(0, 1) ? INS_FRONT : INS_REAR;
      else
        r.mode = $urandom_range(0, 1) ? REM_FRONT : REM_REAR;
      case ($urandom_range(0, 19))
        0:       r.value = 32'h7fffffff;
        1:       r.value = 32'h80000000;
        2:       r.value = 0;
        3:       r.value = -1;
        default: r.value = $urandom;
      endcase
      send_req(r, 1'b0, 0, bdq_pkg::ST_OK);
      if (r.mode <= LIST_ALL) counted++;
    end
    cmd_valid <= 1'b0;
    burst = 1'b0;

    while (owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bounded_deque_tb: PASS");
    end else begin
      $display("bounded_deque_tb: FAIL");
    end
    $finish;
  end

endmodule
